// File: sv/cart_pkg.sv
// Shared types and constants for the command ack and retry tracker.
// Used by cart_ctrl, cart_dp and command_ack_retry_tracker; depends on nothing.
package cart_pkg;

    localparam int MaxPending = 8;
    localparam int CountW = $clog2(MaxPending + 1);
    localparam int PtrW = (MaxPending > 1) ? $clog2(MaxPending) : 1;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] KIND_TRANSMIT = 3'd0;
    localparam logic [2:0] KIND_SUCCEEDED = 3'd1;
    localparam logic [2:0] KIND_NACK = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT = 3'd3;
    localparam logic [2:0] KIND_FULL = 3'd4;

    localparam logic [1:0] CFG_MAX_RETRIES = 2'd0;
    localparam logic [1:0] CFG_RETRY_DELAY = 2'd1;

    localparam logic [3:0] MAX_RETRIES_RESET = 4'd3;
    localparam logic [15:0] RETRY_DELAY_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] command_id;
        logic [15:0] msg_handle;
        logic [7:0]  ack_result;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_command_id;
        logic [15:0] out_msg_handle;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_ACK,
        ST_AGE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic send;
        logic age;
        logic ack_hit;
        logic tick_hit;
        logic ptr_dec;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic count_zero;
        logic ptr_zero;
        logic id_match;
        logic due;
        logic out_free;
    } stat_t;

endpackage

// File: sv/command_ack_retry_tracker.sv
// A send is accepted in the idle state; the send state then appends the entry and loads
// the transmit or table-full result once the output is free. An ack or a tick moves the
// scan pointer over one table entry per cycle from newest to oldest, unless a result
// waits for a free output; a tick first counts every entry down together in ST_AGE. A new
// request is accepted once the controller has finished the previous one. Results leave
// one per cycle through an output register while rsp_stall is low, so a waiting result
// does not block the next request, but a result that cannot be loaded holds the scan.
module command_ack_retry_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cart_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cart_pkg::rsp_t  rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    cart_pkg::ctrl_t  ctl;
    cart_pkg::stat_t  sts;
    cart_pkg::state_t state;

    assign cfg_ready = 1'b1;

    cart_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .sts       (sts),
        .ctl       (ctl),
        .state     (state),
        .req_stall (req_stall)
    );

    cart_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!rsp_valid || !rsp_stall))
        else $error("Result loaded while the output register was still held.");

    a_send_state: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.cmd == cart_pkg::CMD_SEND)
        |=> (state == cart_pkg::ST_SEND))
        else $error("Accepted send request did not enter the send state.");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("Result register reloaded while stalled.");

endmodule

// File: sv/cart_ctrl.sv
// Controller state machine for the command ack and retry tracker.
// Depends on cart_pkg; drives the datapath cart_dp through ctrl_t and reads stat_t.
module cart_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_cmd,
    input  cart_pkg::stat_t   sts,
    output cart_pkg::ctrl_t   ctl,
    output cart_pkg::state_t  state,
    output logic              req_stall
);

    cart_pkg::state_t state_reg;
    cart_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cart_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            cart_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load = 1'b1;
                    case (req_cmd)
                        cart_pkg::CMD_SEND: state_next = cart_pkg::ST_SEND;
                        cart_pkg::CMD_ACK:  state_next = cart_pkg::ST_ACK;
                        cart_pkg::CMD_TICK: state_next = cart_pkg::ST_AGE;
                        default:            state_next = cart_pkg::ST_IDLE;
                    endcase
                end
            end
            cart_pkg::ST_SEND:
            begin
                if (sts.out_free)
                begin
                    ctl.send = 1'b1;
                    state_next = cart_pkg::ST_IDLE;
                end
            end
            cart_pkg::ST_ACK:
            begin
                if (sts.count_zero)
                begin
                    state_next = cart_pkg::ST_IDLE;
                end
                else if (sts.id_match)
                begin
                    if (sts.out_free)
                    begin
                        ctl.ack_hit = 1'b1;
                        state_next = cart_pkg::ST_IDLE;
                    end
                end
                else if (sts.ptr_zero)
                begin
                    state_next = cart_pkg::ST_IDLE;
                end
                else
                begin
                    ctl.ptr_dec = 1'b1;
                end
            end
            cart_pkg::ST_AGE:
            begin
                if (sts.count_zero)
                begin
                    state_next = cart_pkg::ST_IDLE;
                end
                else
                begin
                    ctl.age = 1'b1;
                    state_next = cart_pkg::ST_SCAN;
                end
            end
            cart_pkg::ST_SCAN:
            begin
                if (!sts.due || sts.out_free)
                begin
                    ctl.tick_hit = sts.due;
                    if (sts.ptr_zero)
                    begin
                        state_next = cart_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ctl.ptr_dec = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = cart_pkg::ST_IDLE;
            end
        endcase
        ctl.emit = ctl.send | ctl.ack_hit | ctl.tick_hit;
    end

    assign state = state_reg;
    assign req_stall = (state_reg != cart_pkg::ST_IDLE);

endmodule

// File: sv/cart_dp.sv
// Datapath of the command ack and retry tracker: pending table, scan pointer,
// configuration registers and result register. Depends on cart_pkg; steered by cart_ctrl.
module cart_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  cart_pkg::req_t   req,
    input  cart_pkg::ctrl_t  ctl,
    output cart_pkg::stat_t  sts,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output cart_pkg::rsp_t   rsp
);

    localparam int N = cart_pkg::MaxPending;

    logic [15:0] ent_id_reg [N];
    logic [15:0] ent_handle_reg [N];
    logic [3:0]  ent_retries_reg [N];
    logic [15:0] ent_countdown_reg [N];
    logic [N-1:0] due_reg;

    logic [cart_pkg::CountW-1:0] count_reg;
    logic [cart_pkg::PtrW-1:0]   ptr_reg;
    logic [3:0]                  max_retries_reg;
    logic [15:0]                 retry_delay_reg;
    cart_pkg::req_t              req_reg;
    cart_pkg::rsp_t              rsp_reg;
    cart_pkg::rsp_t              rsp_next;
    logic                        rsp_valid_reg;

    logic [N-1:0] lower_mask;
    logic [N-1:0] age_due;
    logic [15:0]  age_cd [N];
    logic         full;
    logic         retries_zero;
    logic         remove;
    logic         lower_due;

    assign full = (count_reg == cart_pkg::CountW'(N));
    assign retries_zero = (ent_retries_reg[ptr_reg] == 4'd0);
    assign remove = ctl.ack_hit | (ctl.tick_hit & retries_zero);

    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            lower_mask[j] = (cart_pkg::PtrW'(j) < ptr_reg);
            age_cd[j] = (ent_countdown_reg[j] != 16'd0) ? ent_countdown_reg[j] - 16'd1 : 16'd0;
            age_due[j] = (cart_pkg::CountW'(j) < count_reg) && (age_cd[j] == 16'd0);
        end
    end

    assign lower_due = |(due_reg & lower_mask);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= req;
        end
        if (ctl.age)
        begin
            due_reg <= age_due;
            for (int j = 0; j < N; j++)
            begin
                ent_countdown_reg[j] <= age_cd[j];
            end
        end
        if (ctl.send && !full)
        begin
            ent_id_reg[count_reg[cart_pkg::PtrW-1:0]] <= req_reg.command_id;
            ent_handle_reg[count_reg[cart_pkg::PtrW-1:0]] <= req_reg.msg_handle;
            ent_retries_reg[count_reg[cart_pkg::PtrW-1:0]] <= max_retries_reg;
            ent_countdown_reg[count_reg[cart_pkg::PtrW-1:0]] <= retry_delay_reg;
        end
        if (ctl.tick_hit && !retries_zero)
        begin
            ent_retries_reg[ptr_reg] <= ent_retries_reg[ptr_reg] - 4'd1;
            ent_countdown_reg[ptr_reg] <= retry_delay_reg;
        end
        if (remove)
        begin
            for (int j = 0; j < N - 1; j++)
            begin
                if (cart_pkg::PtrW'(j) >= ptr_reg)
                begin
                    ent_id_reg[j] <= ent_id_reg[j + 1];
                    ent_handle_reg[j] <= ent_handle_reg[j + 1];
                    ent_retries_reg[j] <= ent_retries_reg[j + 1];
                    ent_countdown_reg[j] <= ent_countdown_reg[j + 1];
                end
            end
        end
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (ctl.send)
        begin
            rsp_next.kind = full ? cart_pkg::KIND_FULL : cart_pkg::KIND_TRANSMIT;
            rsp_next.out_command_id = req_reg.command_id;
            rsp_next.out_msg_handle = req_reg.msg_handle;
            rsp_next.last = 1'b1;
        end
        else if (ctl.ack_hit)
        begin
            rsp_next.kind = (req_reg.ack_result == 8'd0) ? cart_pkg::KIND_SUCCEEDED
                                                         : cart_pkg::KIND_NACK;
            rsp_next.out_command_id = ent_id_reg[ptr_reg];
            rsp_next.out_msg_handle = ent_handle_reg[ptr_reg];
            rsp_next.last = 1'b1;
        end
        else if (ctl.tick_hit)
        begin
            rsp_next.kind = retries_zero ? cart_pkg::KIND_TIMEOUT : cart_pkg::KIND_TRANSMIT;
            rsp_next.out_command_id = ent_id_reg[ptr_reg];
            rsp_next.out_msg_handle = ent_handle_reg[ptr_reg];
            rsp_next.last = !lower_due;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg <= '0;
            rsp_valid_reg <= 1'b0;
            max_retries_reg <= cart_pkg::MAX_RETRIES_RESET;
            retry_delay_reg <= cart_pkg::RETRY_DELAY_RESET;
        end
        else
        begin
            if (ctl.load)
            begin
                ptr_reg <= cart_pkg::PtrW'(count_reg - cart_pkg::CountW'(1));
            end
            else if (ctl.ptr_dec)
            begin
                ptr_reg <= ptr_reg - cart_pkg::PtrW'(1);
            end
            if (ctl.send && !full)
            begin
                count_reg <= count_reg + cart_pkg::CountW'(1);
            end
            else if (remove)
            begin
                count_reg <= count_reg - cart_pkg::CountW'(1);
            end
            rsp_valid_reg <= ctl.emit | (rsp_valid_reg & rsp_stall);
            if (cfg_write)
            begin
                case (cfg_index)
                    cart_pkg::CFG_MAX_RETRIES: max_retries_reg <= cfg_data[3:0];
                    cart_pkg::CFG_RETRY_DELAY: retry_delay_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.ptr_zero = (ptr_reg == '0);
    assign sts.id_match = (ent_id_reg[ptr_reg] == req_reg.command_id);
    assign sts.due = due_reg[ptr_reg];
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

// File: tb/command_ack_retry_tracker_tb.sv
// Self-checking testbench for command_ack_retry_tracker: sends, acks and ticks under several
// retry settings, predicted by a scoreboard class that keeps its own copy of the pending list.
// Depends on cart_pkg and the command_ack_retry_tracker RTL only.
`timescale 1ns / 1ps

module command_ack_retry_tracker_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;
    localparam int DRAIN_CYCLES = 3 * cart_pkg::MaxPending + 16;
    localparam int PHASE_ITEMS = 24;

    class retry_table_predictor;
        cart_pkg::rsp_t awaited_results[$];
        logic [3:0]     retries_setting;
        logic [15:0]    delay_setting;
        logic [15:0]    pend_id[cart_pkg::MaxPending];
        logic [15:0]    pend_handle[cart_pkg::MaxPending];
        logic [3:0]     pend_retries[cart_pkg::MaxPending];
        logic [15:0]    pend_countdown[cart_pkg::MaxPending];
        int             pend_count;
        int             mismatches;
        int             results_checked;
        int             sends;
        int             acks;
        int             ticks;
        int             ignored;

        function new();
            retries_setting = cart_pkg::MAX_RETRIES_RESET;
            delay_setting = cart_pkg::RETRY_DELAY_RESET;
            pend_count = 0;
            mismatches = 0;
            results_checked = 0;
            sends = 0;
            acks = 0;
            ticks = 0;
            ignored = 0;
        endfunction

        function void set_config(logic [1:0] index, logic [15:0] data);
            if (index == cart_pkg::CFG_MAX_RETRIES)
                retries_setting = data[3:0];
            else if (index == cart_pkg::CFG_RETRY_DELAY)
                delay_setting = data;
        endfunction

        function cart_pkg::rsp_t make_result(logic [2:0] k, logic [15:0] id,
                                             logic [15:0] handle);
            return cart_pkg::rsp_t'{kind: k, out_command_id: id, out_msg_handle: handle,
                                    last: 1'b0};
        endfunction

        function void remove_entry(int pos);
            for (int j = pos; j + 1 < pend_count; j++)
            begin
                pend_id[j] = pend_id[j + 1];
                pend_handle[j] = pend_handle[j + 1];
                pend_retries[j] = pend_retries[j + 1];
                pend_countdown[j] = pend_countdown[j + 1];
            end
            pend_count--;
        endfunction

        function void note_request(cart_pkg::req_t r);
            cart_pkg::rsp_t batch[$];
            int             p;
            case (r.cmd)
                cart_pkg::CMD_SEND:
                begin
                    sends++;
                    if (pend_count >= cart_pkg::MaxPending)
                    begin
                        batch.push_back(make_result(cart_pkg::KIND_FULL, r.command_id,
                                                    r.msg_handle));
                    end
                    else
                    begin
                        pend_id[pend_count] = r.command_id;
                        pend_handle[pend_count] = r.msg_handle;
                        pend_retries[pend_count] = retries_setting;
                        pend_countdown[pend_count] = delay_setting;
                        pend_count++;
                        batch.push_back(make_result(cart_pkg::KIND_TRANSMIT, r.command_id,
                                                    r.msg_handle));
                    end
                end
                cart_pkg::CMD_ACK:
                begin
                    acks++;
                    for (int i = pend_count; i > 0; i--)
                    begin
                        p = i - 1;
                        if (pend_id[p] == r.command_id)
                        begin
                            batch.push_back(make_result(
                                (r.ack_result == 8'd0) ? cart_pkg::KIND_SUCCEEDED
                                                       : cart_pkg::KIND_NACK,
                                pend_id[p], pend_handle[p]));
                            remove_entry(p);
                            break;
                        end
                    end
                end
                cart_pkg::CMD_TICK:
                begin
                    ticks++;
                    for (int i = pend_count; i > 0; i--)
                    begin
                        p = i - 1;
                        if (pend_countdown[p] != 16'd0)
                            pend_countdown[p]--;
                        if (pend_countdown[p] != 16'd0)
                            continue;
                        if (pend_retries[p] != 4'd0)
                        begin
                            pend_retries[p]--;
                            pend_countdown[p] = delay_setting;
                            batch.push_back(make_result(cart_pkg::KIND_TRANSMIT, pend_id[p],
                                                        pend_handle[p]));
                        end
                        else
                        begin
                            batch.push_back(make_result(cart_pkg::KIND_TIMEOUT, pend_id[p],
                                                        pend_handle[p]));
                            remove_entry(p);
                        end
                    end
                end
                default:
                    ignored++;
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                awaited_results.push_back(batch[i]);
        endfunction

        function void check_result(cart_pkg::rsp_t got);
            cart_pkg::rsp_t want;
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                $error("Unexpected result: kind %0d id %h handle %h last %0d",
                       got.kind, got.out_command_id, got.out_msg_handle, got.last);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.out_command_id !== want.out_command_id)
            begin
                $error("out_command_id: expected %h, actual %h",
                       want.out_command_id, got.out_command_id);
                mismatches++;
            end
            if (got.out_msg_handle !== want.out_msg_handle)
            begin
                $error("out_msg_handle: expected %h, actual %h",
                       want.out_msg_handle, got.out_msg_handle);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    cart_pkg::req_t req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    cart_pkg::rsp_t rsp;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = '0;
    logic [15:0]    cfg_data = '0;

    bit                   no_idle = 1'b0;
    retry_table_predictor model = new();

    command_ack_retry_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
            model.check_result(rsp);
        rsp_stall <= !no_idle && ($urandom_range(0, 99) < 7);
    end

    function automatic cart_pkg::req_t make_req(logic [1:0] c, logic [15:0] id,
                                                logic [15:0] handle, logic [7:0] code);
        return cart_pkg::req_t'{cmd: c, command_id: id, msg_handle: handle, ack_result: code};
    endfunction

    function automatic cart_pkg::req_t random_request();
        cart_pkg::req_t r;
        int unsigned    pick;
        r = make_req(cart_pkg::CMD_SEND, 16'($urandom), 16'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 36)
        begin
            r.cmd = cart_pkg::CMD_SEND;
            if ($urandom_range(0, 9) < 6)
                r.command_id = 16'($urandom_range(0, 7));
        end
        else if (pick < 66)
        begin
            r.cmd = cart_pkg::CMD_ACK;
            if (model.pend_count > 0 && $urandom_range(0, 9) < 8)
                r.command_id = model.pend_id[$urandom_range(0, model.pend_count - 1)];
            r.ack_result = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        end
        else if (pick < 95)
        begin
            r.cmd = cart_pkg::CMD_TICK;
        end
        else
        begin
            r.cmd = CMD_UNUSED;
        end
        return r;
    endfunction

    task automatic drive_request(input cart_pkg::req_t item);
        while (!no_idle && $urandom_range(0, 99) < 7)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        model.note_request(item);
    endtask

    task automatic finish_phase();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (model.awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [3:0] retries, input logic [15:0] delay,
                             input logic [1:0] spare_index);
        logic [1:0]  idx[3];
        logic [15:0] val[3];
        idx = '{cart_pkg::CFG_MAX_RETRIES, cart_pkg::CFG_RETRY_DELAY, spare_index};
        val = '{{12'd0, retries}, delay, 16'($urandom)};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            model.set_config(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        cart_pkg::req_t directed[$];
        int             phase_items;
        logic [3:0]     phase_retries[5];
        logic [15:0]    phase_delay[5];
        cart_pkg::req_t item;

        phase_retries = '{4'd0, 4'd15, 4'd2, 4'd4, 4'd3};
        phase_delay = '{16'd0, 16'd0, 16'd3, 16'hFFFF, 16'd1000};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(4'd1, 16'd2, CFG_SPARE_LO);
        directed.push_back(make_req(cart_pkg::CMD_SEND, 16'h0000, 16'h0000, 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_SEND, 16'hFFFF, 16'hFFFF, 8'hFF));
        directed.push_back(make_req(cart_pkg::CMD_SEND, 16'h0005, 16'h1111, 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_SEND, 16'h0005, 16'h2222, 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_ACK, 16'h0005, 16'h0000, 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_ACK, 16'h1234, 16'hFFFF, 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_ACK, 16'h0005, 16'h0000, 8'hFF));
        directed.push_back(make_req(cart_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF));
        directed.push_back(make_req(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
        directed.push_back(make_req(cart_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00));
        for (int i = 0; i < cart_pkg::MaxPending; i++)
            directed.push_back(make_req(cart_pkg::CMD_SEND, 16'(16'h0010 + i),
                                        16'(16'hA000 + i), 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_SEND, 16'hABCD, 16'h5A5A, 8'h00));
        directed.push_back(make_req(cart_pkg::CMD_ACK, 16'h0010, 16'h0000, 8'h80));
        for (int i = 0; i < 4; i++)
            directed.push_back(make_req(cart_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00));
        foreach (directed[i])
            drive_request(directed[i]);
        finish_phase();

        for (int ph = 0; ph < 5; ph++)
        begin
            configure(phase_retries[ph], phase_delay[ph], ph[0] ? CFG_SPARE_HI : CFG_SPARE_LO);
            no_idle = (ph == 2);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                item = random_request();
                drive_request(item);
                if (item.cmd != CMD_UNUSED)
                    phase_items++;
            end
            finish_phase();
        end
        no_idle = 1'b0;

        $display("Run covered %0d sends, %0d acks, %0d ticks and %0d unused commands",
                 model.sends, model.acks, model.ticks, model.ignored);
        $display("over six retry settings; %0d results checked, %0d mismatches",
                 model.results_checked, model.mismatches);
        if (model.mismatches == 0 && model.awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still awaited", model.awaited_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
